FILE: design/sprite_mask_collision_top_macros.svh
// Assertion helpers shared by the checker.
`ifndef SPRITE_MASK_COLLISION_TOP_MACROS_SVH
`define SPRITE_MASK_COLLISION_TOP_MACROS_SVH

// Same-cycle implication.
`define SMC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/smc_pkg.sv
package smc_pkg;

   localparam int MAX_SIDE  = 64;
   localparam int ROW_W     = 64;
   localparam int IDX_W     = $clog2(MAX_SIDE);
   localparam int ROWIDX_W  = 6;
   localparam int MODE_W    = 2;
   localparam int POS_W     = 16;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD_A = 2'd0,
      MODE_LOAD_B = 2'd1,
      MODE_QUERY  = 2'd2
   } smc_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH_A  = 2'd0,
      CSR_HEIGHT_A = 2'd1,
      CSR_WIDTH_B  = 2'd2,
      CSR_HEIGHT_B = 2'd3
   } smc_csr_type;

   typedef struct packed {
      logic signed [POS_W-1:0] a_x;
      logic signed [POS_W-1:0] a_y;
      logic signed [POS_W-1:0] b_x;
      logic signed [POS_W-1:0] b_y;
   } smc_query_type;

   typedef struct packed {
      logic [CFG_W-1:0] width_a;
      logic [CFG_W-1:0] height_a;
      logic [CFG_W-1:0] width_b;
      logic [CFG_W-1:0] height_b;
   } smc_sides_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr_a;
      logic [IDX_W-1:0] addr_b;
   } smc_rd_req_type;

   typedef struct packed {
      logic boxes_overlap;
      logic hit;
   } smc_result_type;

endpackage

FILE: design/smc_channels.sv
interface smc_req_if;
   import smc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic [ROWIDX_W-1:0]        row_index;
   logic [ROW_W-1:0]           row_bits;
   logic signed [POS_W-1:0]    a_x;
   logic signed [POS_W-1:0]    a_y;
   logic signed [POS_W-1:0]    b_x;
   logic signed [POS_W-1:0]    b_y;

   modport source (output valid, mode, row_index, row_bits, a_x, a_y, b_x, b_y,
                   input ready);
   modport sink   (input valid, mode, row_index, row_bits, a_x, a_y, b_x, b_y,
                   output ready);
endinterface

interface smc_rsp_if;
   logic valid;
   logic ready;
   logic boxes_overlap;
   logic hit;

   modport source (output valid, boxes_overlap, hit, input ready);
   modport sink   (input valid, boxes_overlap, hit, output ready);
endinterface

FILE: design/smc_mask_ram.sv
module smc_mask_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [smc_pkg::IDX_W-1:0]  wr_addr,
   input  logic [smc_pkg::ROW_W-1:0]  wr_data,
   input  logic                       rd_en,
   input  logic [smc_pkg::IDX_W-1:0]  rd_addr,
   output logic [smc_pkg::ROW_W-1:0]  rd_data
);
   import smc_pkg::*;

   logic [ROW_W-1:0] mem [MAX_SIDE];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/smc_walker.sv
module smc_walker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  smc_pkg::smc_query_type     query,
   input  smc_pkg::smc_sides_type     sides,
   output logic                       idle,
   output smc_pkg::smc_rd_req_type    rd_req,
   input  logic [smc_pkg::ROW_W-1:0]  rd_data_a,
   input  logic [smc_pkg::ROW_W-1:0]  rd_data_b,
   output logic                       done,
   input  logic                       take,
   output smc_pkg::smc_result_type    result
);
   import smc_pkg::*;

   localparam int SIDE_W  = IDX_W + 1;
   localparam int EXT_W   = POS_W + 2;
   localparam int SHIFT_W = $clog2(ROW_W);
   localparam int KEEP_W  = $clog2(ROW_W) + 1;
   localparam logic signed [EXT_W-1:0] SHIFT_MAX = EXT_W'(ROW_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE,
      ST_BOX,
      ST_SPAN,
      ST_WALK,
      ST_DONE
   } state_type;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
      if (v > CFG_W'(MAX_SIDE)) begin
         return SIDE_W'(MAX_SIDE);
      end
      return SIDE_W'(v);
   endfunction

   function automatic logic signed [EXT_W-1:0] smax(input logic signed [EXT_W-1:0] p,
                                                    input logic signed [EXT_W-1:0] q);
      return (p > q) ? p : q;
   endfunction

   function automatic logic signed [EXT_W-1:0] smin(input logic signed [EXT_W-1:0] p,
                                                    input logic signed [EXT_W-1:0] q);
      return (p < q) ? p : q;
   endfunction

   state_type               state_ff;
   logic signed [POS_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [SIDE_W-1:0]       wa_ff, ha_ff, wb_ff, hb_ff;
   logic signed [EXT_W-1:0] ra_ff, ba_ff, rb_ff, bb_ff;
   logic signed [EXT_W-1:0] ct_ff, cb_ff, cl_ff, cr_ff;
   logic                    overlap_ff;
   logic [ROW_W-1:0]        keep_ff;
   logic [SHIFT_W-1:0]      sa_ff, sb_ff;
   logic [IDX_W-1:0]        ia_ff, ib_ff;
   logic [SIDE_W-1:0]       rows_ff;
   logic                    pend_ff;
   logic                    hit_ff;

   logic signed [EXT_W-1:0] ax_e, ay_e, bx_e, by_e;
   logic signed [EXT_W-1:0] ra_in, ba_in, rb_in, bb_in;
   logic                    overlap_in;
   logic signed [EXT_W-1:0] ncol_in, nrow_in, sa_in, sb_in, ia_in, ib_in;
   logic [KEEP_W-1:0]       ncol_nar;
   logic [ROW_W-1:0]        keep_in;
   logic                    go_in;
   logic                    issue;
   logic                    row_hit_in;

   assign ax_e = EXT_W'(ax_ff);
   assign ay_e = EXT_W'(ay_ff);
   assign bx_e = EXT_W'(bx_ff);
   assign by_e = EXT_W'(by_ff);

   // Right and bottom edges, exclusive.
   assign ra_in = ax_e + signed'(EXT_W'(wa_ff));
   assign ba_in = ay_e + signed'(EXT_W'(ha_ff));
   assign rb_in = bx_e + signed'(EXT_W'(wb_ff));
   assign bb_in = by_e + signed'(EXT_W'(hb_ff));

   assign overlap_in = !(ra_ff <= bx_e || ax_e >= rb_ff || ay_e >= bb_ff || ba_ff <= by_e);

   // Overlap extent and mask alignment.
   assign ncol_in = cr_ff - cl_ff;
   assign nrow_in = cb_ff - ct_ff;
   assign sa_in   = cl_ff - ax_e;
   assign sb_in   = cl_ff - bx_e;
   assign ia_in   = ct_ff - ay_e;
   assign ib_in   = ct_ff - by_e;

   assign go_in = overlap_ff
                  && !ncol_in[EXT_W-1] && (ncol_in != '0)
                  && !nrow_in[EXT_W-1] && (nrow_in != '0)
                  && !sa_in[EXT_W-1] && (sa_in <= SHIFT_MAX)
                  && !sb_in[EXT_W-1] && (sb_in <= SHIFT_MAX);

   assign ncol_nar = ncol_in[KEEP_W-1:0];
   assign keep_in  = (ncol_nar >= KEEP_W'(ROW_W)) ? '1
                   : ((ROW_W'(1) << ncol_nar) - ROW_W'(1));

   assign issue = (state_ff == ST_WALK) && (rows_ff != '0) && !row_hit_in;

   assign row_hit_in = pend_ff
                       && (((rd_data_a >> sa_ff) & (rd_data_b >> sb_ff) & keep_ff) != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  ax_ff    <= query.a_x;
                  ay_ff    <= query.a_y;
                  bx_ff    <= query.b_x;
                  by_ff    <= query.b_y;
                  wa_ff    <= clamp_side(sides.width_a);
                  ha_ff    <= clamp_side(sides.height_a);
                  wb_ff    <= clamp_side(sides.width_b);
                  hb_ff    <= clamp_side(sides.height_b);
                  state_ff <= ST_EDGE;
               end
            end
            ST_EDGE: begin
               ra_ff    <= ra_in;
               ba_ff    <= ba_in;
               rb_ff    <= rb_in;
               bb_ff    <= bb_in;
               state_ff <= ST_BOX;
            end
            ST_BOX: begin
               overlap_ff <= overlap_in;
               ct_ff      <= smax(ay_e, by_e);
               cb_ff      <= smin(ba_ff, bb_ff);
               cl_ff      <= smax(ax_e, bx_e);
               cr_ff      <= smin(ra_ff, rb_ff);
               state_ff   <= ST_SPAN;
            end
            ST_SPAN: begin
               keep_ff <= keep_in;
               sa_ff   <= sa_in[SHIFT_W-1:0];
               sb_ff   <= sb_in[SHIFT_W-1:0];
               ia_ff   <= ia_in[IDX_W-1:0];
               ib_ff   <= ib_in[IDX_W-1:0];
               rows_ff <= nrow_in[SIDE_W-1:0];
               hit_ff  <= 1'b0;
               pend_ff <= 1'b0;
               state_ff <= go_in ? ST_WALK : ST_DONE;
            end
            ST_WALK: begin
               if (issue) begin
                  ia_ff   <= ia_ff + IDX_W'(1);
                  ib_ff   <= ib_ff + IDX_W'(1);
                  rows_ff <= rows_ff - SIDE_W'(1);
               end
               pend_ff <= issue;
               if (row_hit_in) begin
                  hit_ff <= 1'b1;
               end
               if (row_hit_in || (rows_ff == '0 && !pend_ff)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               pend_ff <= 1'b0;
               if (take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign idle          = (state_ff == ST_IDLE);
   assign done          = (state_ff == ST_DONE);
   assign rd_req.en     = issue;
   assign rd_req.addr_a = ia_ff;
   assign rd_req.addr_b = ib_ff;
   assign result.boxes_overlap = overlap_ff;
   assign result.hit           = hit_ff;

endmodule

FILE: design/sprite_mask_collision_top.sv
// Channel  Dir  Beat carries
// req      in   mode, row_index, row_bits, a_x, a_y, b_x, b_y
// rsp      out  boxes_overlap, hit (one beat per query, none for loads)
// csr      in   csr_we, csr_index, csr_wdata (sprite sizes, no read-back)
//
// A load beat writes one mask row; the next beat may follow at once.
// A query walks its R overlap rows (at most MAX_SIDE), reading one row of each mask store
// per cycle; a hit on a row ends the walk early, and a query with no rows to walk skips it.
// Reset is synchronous; the mask stores have no reset and need no clearing pass.
// req stalls only during reset and while a query is in flight; a finished result waiting on rsp
// does not block further beats, though the next query holds at its end until rsp frees.
module sprite_mask_collision_top (
   input  logic                          clock,
   input  logic                          reset,
   smc_req_if.sink                       req_bus,
   smc_rsp_if.source                     rsp_bus,
   input  logic                          csr_we,
   input  logic [smc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [smc_pkg::CFG_W-1:0]     csr_wdata
);
   import smc_pkg::*;

   // Sprite size registers.
   logic [CFG_W-1:0] width_a_ff, height_a_ff, width_b_ff, height_b_ff;

   // Output register toward rsp.
   logic             rsp_valid_ff;
   smc_result_type   rsp_result_ff;

   logic             walker_idle;
   logic             walker_done;
   logic             walker_take;
   smc_result_type   walker_result;
   smc_rd_req_type   rd_req;
   smc_query_type    query;
   smc_sides_type    sides;
   logic [ROW_W-1:0] rd_data_a, rd_data_b;

   logic             accept;
   logic             row_in_range;
   logic             load_a, load_b, start_query;

   // Hold off new beats during reset and while a query occupies the walker; this also keeps loads
   // from touching a row that the walk is reading.
   assign req_bus.ready = walker_idle && !reset;
   assign accept        = req_bus.valid && req_bus.ready;

   // Drop loads aimed past the last mask row.
   assign row_in_range = (ROWIDX_W + 1)'(req_bus.row_index) < (ROWIDX_W + 1)'(MAX_SIDE);
   assign load_a       = accept && (req_bus.mode == MODE_LOAD_A) && row_in_range;
   assign load_b       = accept && (req_bus.mode == MODE_LOAD_B) && row_in_range;
   assign start_query  = accept && (req_bus.mode == MODE_QUERY);

   assign query.a_x = req_bus.a_x;
   assign query.a_y = req_bus.a_y;
   assign query.b_x = req_bus.b_x;
   assign query.b_y = req_bus.b_y;

   assign sides.width_a  = width_a_ff;
   assign sides.height_a = height_a_ff;
   assign sides.width_b  = width_b_ff;
   assign sides.height_b = height_b_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_a_ff  <= CFG_RESET;
         height_a_ff <= CFG_RESET;
         width_b_ff  <= CFG_RESET;
         height_b_ff <= CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH_A:  width_a_ff  <= csr_wdata;
            CSR_HEIGHT_A: height_a_ff <= csr_wdata;
            CSR_WIDTH_B:  width_b_ff  <= csr_wdata;
            CSR_HEIGHT_B: height_b_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   smc_mask_ram u_mask_a (
      .clock   (clock),
      .wr_en   (load_a),
      .wr_addr (req_bus.row_index[IDX_W-1:0]),
      .wr_data (req_bus.row_bits),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr_a),
      .rd_data (rd_data_a)
   );

   smc_mask_ram u_mask_b (
      .clock   (clock),
      .wr_en   (load_b),
      .wr_addr (req_bus.row_index[IDX_W-1:0]),
      .wr_data (req_bus.row_bits),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr_b),
      .rd_data (rd_data_b)
   );

   smc_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .start     (start_query),
      .query     (query),
      .sides     (sides),
      .idle      (walker_idle),
      .rd_req    (rd_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .done      (walker_done),
      .take      (walker_take),
      .result    (walker_result)
   );

   // Advance the result into the output register once it is free or draining.
   assign walker_take = walker_done && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (walker_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (walker_take) begin
         rsp_result_ff <= walker_result;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.boxes_overlap = rsp_result_ff.boxes_overlap;
   assign rsp_bus.hit           = rsp_result_ff.hit;

endmodule

FILE: design/smc_checker.sv
`include "sprite_mask_collision_top_macros.svh"

module smc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [smc_pkg::MODE_W-1:0] req_mode,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_boxes_overlap,
   input logic                       rsp_hit
);
   import smc_pkg::*;

   // A stalled result beat holds.
   `SMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_boxes_overlap), "rsp beat changed while stalled")

   // A hit only inside overlapping boxes.
   `SMC_ASSERT_NOW(a_hit_in_box, clock, reset, rsp_valid, !rsp_hit || rsp_boxes_overlap, "hit reported without box overlap")

   // A query beat occupies the walker.
   `SMC_ASSERT_NEXT(a_query_busy, clock, reset, req_valid && req_ready && req_mode == MODE_QUERY, !req_ready, "req ready right after a query beat")

   // Load and unused beats never stall the next one.
   `SMC_ASSERT_NEXT(a_load_free, clock, reset, req_valid && req_ready && req_mode != MODE_QUERY, req_ready, "req stalled after a load beat")

endmodule

bind sprite_mask_collision_top smc_checker u_smc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .req_mode          (req_bus.mode),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_boxes_overlap (rsp_bus.boxes_overlap),
   .rsp_hit           (rsp_bus.hit)
);

FILE: test/sprite_mask_collision_top_tb.sv
module sprite_mask_collision_top_tb;
   import smc_pkg::*;

   // Mode 3 has no enum member; the block must swallow such a beat silently.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int N_DIRECTED      = 25;
   localparam int N_PHASES        = 8;
   localparam int BEATS_PER_PHASE = 125;
   // A query walks at most MAX_SIDE rows plus the edge, box and span states before the walk.
   localparam int DRAIN_CYCLES    = MAX_SIDE + 16;
   localparam int IDLE_PCT        = 47;
   localparam int BOTH_IDLE_PCT   = 30;
   localparam int TIMEOUT_UNITS   = 3_000_000;

   localparam smc_result_type RES_CLEAR = '{1'b0, 1'b0};
   localparam smc_result_type RES_BOX   = '{1'b1, 1'b0};

   typedef enum logic {STEP_BEAT, STEP_SIZES} step_kind_type;

   // One row of the directed table: either a req beat or a full set of sprite sizes.
   typedef struct packed {
      step_kind_type       kind;
      logic [MODE_W-1:0]   mode;
      logic [ROWIDX_W-1:0] row_index;
      logic [ROW_W-1:0]    row_bits;
      smc_query_type       pos;
      smc_sides_type       sides;
      logic                typed;
      smc_result_type      want;
   } dir_step_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   smc_req_if req_bus ();
   smc_rsp_if rsp_bus ();

   sprite_mask_collision_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block: both mask stores, which rows hold data, and the sizes.
   logic [ROW_W-1:0] mask_a_model [MAX_SIDE];
   logic [ROW_W-1:0] mask_b_model [MAX_SIDE];
   bit               a_loaded [MAX_SIDE];
   bit               b_loaded [MAX_SIDE];
   smc_sides_type    cur_sides;

   // Collision results owed by the block, oldest first.
   smc_result_type   collision_expected [$];

   int               fail_count;
   int               send_idle_pct;
   int               recv_stall_pct;
   dir_step_type     dir_steps [N_DIRECTED];

   // Free-running clock, period 4.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops a result.
   initial begin
      #(TIMEOUT_UNITS);
      $display("[sprite_mask_collision_top] ERROR");
      $finish;
   end

   // Size registers above MAX_SIDE count as MAX_SIDE.
   function automatic int side_px(input logic [CFG_W-1:0] v);
      return (v > CFG_W'(MAX_SIDE)) ? MAX_SIDE : int'(v);
   endfunction

   // Box test on the current sizes; also hand back the overlap rectangle.
   function automatic bit box_overlap(input smc_query_type pos, output int top, output int bot,
                                      output int lft, output int rgt);
      int ax, ay, bx, by, ra, ba, rb, bb;
      ax = $signed(pos.a_x);
      ay = $signed(pos.a_y);
      bx = $signed(pos.b_x);
      by = $signed(pos.b_y);
      ra = ax + side_px(cur_sides.width_a);
      ba = ay + side_px(cur_sides.height_a);
      rb = bx + side_px(cur_sides.width_b);
      bb = by + side_px(cur_sides.height_b);
      top = (ay > by) ? ay : by;
      bot = (ba < bb) ? ba : bb;
      lft = (ax > bx) ? ax : bx;
      rgt = (ra < rb) ? ra : rb;
      return !(ra <= bx || ax >= rb || ay >= bb || ba <= by);
   endfunction

   // Walk the overlap rows, align both masks on its left column and AND them.
   // Empty sprites (a zero side) can still pass the box test but never hit.
   function automatic smc_result_type predict_collision(input smc_query_type pos);
      smc_result_type   res;
      int               top, bot, lft, rgt, n, ax, ay, bx, by;
      logic [ROW_W-1:0] keep, a_bits, b_bits;
      ax = $signed(pos.a_x);
      ay = $signed(pos.a_y);
      bx = $signed(pos.b_x);
      by = $signed(pos.b_y);
      res.boxes_overlap = box_overlap(pos, top, bot, lft, rgt);
      res.hit = 1'b0;
      n = rgt - lft;
      if (res.boxes_overlap && n > 0 && bot > top) begin
         keep = (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
         for (int y = top; y < bot; y++) begin
            a_bits = mask_a_model[y - ay] >> (lft - ax);
            b_bits = mask_b_model[y - by] >> (lft - bx);
            if ((a_bits & b_bits & keep) != '0)
               res.hit = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic smc_query_type rand_pos();
      smc_query_type pos;
      pos.a_x = POS_W'($urandom);
      pos.a_y = POS_W'($urandom);
      pos.b_x = POS_W'($urandom);
      pos.b_y = POS_W'($urandom);
      return pos;
   endfunction

   // Mix of empty, solid, single-pixel, sparse and dense rows so hits stay uncertain.
   function automatic logic [ROW_W-1:0] rand_row_bits();
      logic [ROW_W-1:0] r1, r2, r3;
      r1 = {$urandom, $urandom};
      r2 = {$urandom, $urandom};
      r3 = {$urandom, $urandom};
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return ROW_W'(1) << $urandom_range(ROW_W - 1);
         3, 4, 5: return r1 & r2 & r3;
         default: return r1;
      endcase
   endfunction

   // Place B around A so that most queries overlap or just touch; some scatter
   // anywhere and some sit at the ends of the coordinate range.
   function automatic smc_query_type rand_query();
      smc_query_type pos;
      int            wa, ha, wb, hb, base_x, base_y;
      wa = side_px(cur_sides.width_a);
      ha = side_px(cur_sides.height_a);
      wb = side_px(cur_sides.width_b);
      hb = side_px(cur_sides.height_b);
      pos = rand_pos();
      case ($urandom_range(9))
         0: ;
         1: begin
            base_x = $urandom_range(1) ? 32767 - int'($urandom_range(MAX_SIDE))
                                       : -32768 + int'($urandom_range(MAX_SIDE));
            base_y = $urandom_range(1) ? 32767 - int'($urandom_range(MAX_SIDE))
                                       : -32768 + int'($urandom_range(MAX_SIDE));
            pos.a_x = POS_W'(base_x);
            pos.a_y = POS_W'(base_y);
            pos.b_x = pos.a_x + POS_W'(int'($urandom_range(wa + wb)) - wb);
            pos.b_y = pos.a_y + POS_W'(int'($urandom_range(ha + hb)) - hb);
         end
         default: begin
            pos.b_x = pos.a_x + POS_W'(int'($urandom_range(wa + wb)) - wb);
            pos.b_y = pos.a_y + POS_W'(int'($urandom_range(ha + hb)) - hb);
         end
      endcase
      return pos;
   endfunction

   // Present one beat, hold it until accepted, then fold it into the shadow model.
   // valid stays high on exit so back-to-back beats need no second assignment.
   task automatic drive_beat(input logic [MODE_W-1:0] mode, input logic [ROWIDX_W-1:0] row,
                             input logic [ROW_W-1:0] bits, input smc_query_type pos,
                             input bit typed, input smc_result_type want);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= mode;
      req_bus.row_index <= row;
      req_bus.row_bits  <= bits;
      req_bus.a_x       <= pos.a_x;
      req_bus.a_y       <= pos.a_y;
      req_bus.b_x       <= pos.b_x;
      req_bus.b_y       <= pos.b_y;
      do @(posedge clock); while (!req_bus.ready);
      case (mode)
         MODE_LOAD_A: begin
            mask_a_model[row] = bits;
            a_loaded[row]     = 1'b1;
         end
         MODE_LOAD_B: begin
            mask_b_model[row] = bits;
            b_loaded[row]     = 1'b1;
         end
         MODE_QUERY: collision_expected.insert(collision_expected.size(),
                                               typed ? want : predict_collision(pos));
         default: ;
      endcase
   endtask

   // Load every mask row the walk may touch that was never written; take one
   // spare row on each side in case the read port fetches ahead.
   task automatic prime_rows(input smc_query_type pos);
      int top, bot, lft, rgt, ay, by;
      ay = $signed(pos.a_y);
      by = $signed(pos.b_y);
      if (box_overlap(pos, top, bot, lft, rgt)) begin
         for (int y = top - 1; y <= bot; y++) begin
            if (y - ay >= 0 && y - ay < MAX_SIDE && !a_loaded[y - ay])
               drive_beat(MODE_LOAD_A, ROWIDX_W'(y - ay), rand_row_bits(), rand_pos(),
                          1'b0, RES_CLEAR);
            if (y - by >= 0 && y - by < MAX_SIDE && !b_loaded[y - by])
               drive_beat(MODE_LOAD_B, ROWIDX_W'(y - by), rand_row_bits(), rand_pos(),
                          1'b0, RES_CLEAR);
         end
      end
   endtask

   task automatic send_query(input smc_query_type pos, input bit typed,
                             input smc_result_type want);
      prime_rows(pos);
      drive_beat(MODE_QUERY, ROWIDX_W'($urandom), {$urandom, $urandom}, pos, typed, want);
   endtask

   // Drop valid, wait out every owed result, then let a walk in flight finish.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (collision_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four size registers on consecutive edges; only call when idle.
   task automatic write_sides(input smc_sides_type s);
      csr_we    <= 1'b1;
      csr_index <= CSR_WIDTH_A;
      csr_wdata <= s.width_a;
      @(posedge clock);
      csr_index <= CSR_HEIGHT_A;
      csr_wdata <= s.height_a;
      @(posedge clock);
      csr_index <= CSR_WIDTH_B;
      csr_wdata <= s.width_b;
      @(posedge clock);
      csr_index <= CSR_HEIGHT_B;
      csr_wdata <= s.height_b;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_sides = s;
   endtask

   // Result side: check each accepted beat, then pick next cycle's ready.
   initial begin
      smc_result_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (collision_expected.size() == 0) begin
               $error("result beat with no query waiting: boxes_overlap %0b hit %0b",
                      rsp_bus.boxes_overlap, rsp_bus.hit);
               fail_count++;
            end else begin
               want = collision_expected.pop_front();
               if (rsp_bus.boxes_overlap !== want.boxes_overlap) begin
                  $error("boxes_overlap: expected %0b, actual %0b",
                         want.boxes_overlap, rsp_bus.boxes_overlap);
                  fail_count++;
               end
               if (rsp_bus.hit !== want.hit) begin
                  $error("hit: expected %0b, actual %0b", want.hit, rsp_bus.hit);
                  fail_count++;
               end
            end
         end
         rsp_bus.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Stimulus: directed table first, then random phases with new sizes and idling.
   initial begin
      smc_sides_type ph_sides;
      int            pick;

      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_WIDTH_A;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.mode      = MODE_LOAD_A;
      req_bus.row_index = '0;
      req_bus.row_bits  = '0;
      req_bus.a_x       = '0;
      req_bus.a_y       = '0;
      req_bus.b_x       = '0;
      req_bus.b_y       = '0;
      cur_sides         = '{CFG_RESET, CFG_RESET, CFG_RESET, CFG_RESET};
      fail_count        = 0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      for (int r = 0; r < MAX_SIDE; r++) begin
         mask_a_model[r] = '0;
         mask_b_model[r] = '0;
         a_loaded[r]     = 1'b0;
         b_loaded[r]     = 1'b0;
      end

      // Typed results: far apart after reset, edges that only touch, the coordinate
      // extremes, a zero-width sprite crossing a zero-height one, and oversized sides
      // clamped to MAX_SIDE. Everything else goes through the predictor.
      dir_steps = '{
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0, '{16'sd0, 16'sd0, 16'sd100, 16'sd100},
           '0, 1'b1, RES_CLEAR},
         '{STEP_SIZES, MODE_LOAD_A, 6'd0,  64'd0, '0, '{7'd4, 7'd2, 7'd4, 7'd2},
           1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_LOAD_A, 6'd0,  '1,    '0, '0, 1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_LOAD_A, 6'd1,  64'd0, '0, '0, 1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_LOAD_B, 6'd0,  64'd0, '0, '0, 1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_LOAD_B, 6'd1,  64'd5, '0, '0, 1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
           '0, 1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0, '{16'sd0, 16'sd0, 16'sd0, -16'sd1},
           '0, 1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0, '{16'sd0, 16'sd0, 16'sd4, 16'sd0},
           '0, 1'b1, RES_CLEAR},
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0, '{16'sd0, 16'sd0, 16'sd0, 16'sd2},
           '0, 1'b1, RES_CLEAR},
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0,
           '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff}, '0, 1'b1, RES_CLEAR},
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0,
           '{16'sh7fff, 16'sh7fff, 16'sh7ffd, 16'sh7ffe}, '0, 1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0,
           '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, '0, 1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_UNUSED, 6'd63, '1,    '1, '0, 1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_LOAD_A, 6'd63, '1,    '0, '0, 1'b0, RES_CLEAR},
         '{STEP_SIZES, MODE_LOAD_A, 6'd0,  64'd0, '0, '{7'd64, 7'd64, 7'd64, 7'd64},
           1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
           '0, 1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0, '{-16'sd10, 16'sd5, 16'sd50, -16'sd40},
           '0, 1'b0, RES_CLEAR},
         '{STEP_SIZES, MODE_LOAD_A, 6'd0,  64'd0, '0, '{7'd0, 7'd8, 7'd8, 7'd0},
           1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0, '{16'sd0, 16'sd0, -16'sd2, 16'sd3},
           '0, 1'b1, RES_BOX},
         '{STEP_SIZES, MODE_LOAD_A, 6'd0,  64'd0, '0, '{7'd127, 7'd100, 7'd65, 7'd127},
           1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0, '{16'sd0, 16'sd0, 16'sd63, 16'sd63},
           '0, 1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0, '{16'sd0, 16'sd0, 16'sd64, 16'sd0},
           '0, 1'b1, RES_CLEAR},
         '{STEP_SIZES, MODE_LOAD_A, 6'd0,  64'd0, '0, '{7'd1, 7'd1, 7'd1, 7'd1},
           1'b0, RES_CLEAR},
         '{STEP_BEAT,  MODE_QUERY,  6'd0,  64'd0, '{16'sd5, 16'sd5, 16'sd5, 16'sd5},
           '0, 1'b0, RES_CLEAR}
      };

      // Hold reset from the start, then release it once.
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; sizes change only with the block drained.
      foreach (dir_steps[i]) begin
         if (dir_steps[i].kind == STEP_SIZES) begin
            wait_idle();
            write_sides(dir_steps[i].sides);
         end else if (dir_steps[i].mode == MODE_QUERY) begin
            send_query(dir_steps[i].pos, dir_steps[i].typed, dir_steps[i].want);
         end else begin
            drive_beat(dir_steps[i].mode, dir_steps[i].row_index, dir_steps[i].row_bits,
                       dir_steps[i].pos, 1'b0, RES_CLEAR);
         end
      end

      // Random phases: each one drains, picks sizes, then picks an idling pattern.
      for (int p = 0; p < N_PHASES; p++) begin
         wait_idle();
         case (p)
            0: ph_sides = '{7'd64, 7'd64, 7'd64, 7'd64};
            1: ph_sides = '{7'd1, 7'd1, 7'd1, 7'd1};
            2: ph_sides = '{7'd0, 7'd64, 7'd127, 7'd5};
            default: begin
               ph_sides.width_a  = CFG_W'($urandom_range(1, MAX_SIDE));
               ph_sides.height_a = CFG_W'($urandom_range(1, MAX_SIDE));
               ph_sides.width_b  = CFG_W'($urandom_range(1, 16));
               ph_sides.height_b = CFG_W'($urandom_range(1, MAX_SIDE));
            end
         endcase
         write_sides(ph_sides);
         case (p % 4)
            0: begin send_idle_pct = 0;             recv_stall_pct = 0;             end
            1: begin send_idle_pct = IDLE_PCT;      recv_stall_pct = 0;             end
            2: begin send_idle_pct = 0;             recv_stall_pct = IDLE_PCT;      end
            default: begin send_idle_pct = BOTH_IDLE_PCT; recv_stall_pct = BOTH_IDLE_PCT; end
         endcase

         // Mostly loads and queries; a few unused-mode beats as noise.
         for (int k = 0; k < BEATS_PER_PHASE; k++) begin
            pick = $urandom_range(99);
            if (pick < 45)
               drive_beat($urandom_range(1) ? MODE_LOAD_B : MODE_LOAD_A,
                          ROWIDX_W'($urandom_range(MAX_SIDE - 1)), rand_row_bits(),
                          rand_pos(), 1'b0, RES_CLEAR);
            else if (pick < 96)
               send_query(rand_query(), 1'b0, RES_CLEAR);
            else
               drive_beat(MODE_UNUSED, ROWIDX_W'($urandom), {$urandom, $urandom},
                          rand_pos(), 1'b0, RES_CLEAR);
         end
      end

      // Drain the last results and give a late extra beat time to show up.
      wait_idle();
      if (fail_count == 0)
         $display("[sprite_mask_collision_top] OK");
      else
         $display("[sprite_mask_collision_top] ERROR");
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/smc_pkg.sv
design/smc_channels.sv
design/smc_mask_ram.sv
design/smc_walker.sv
design/sprite_mask_collision_top.sv
design/smc_checker.sv
test/sprite_mask_collision_top_tb.sv
